FILE: rtl/gcd_lcm_fraction_unit_defines.svh
// Assertion macros shared by the gcd/lcm/fraction unit.
// Used by glfu_ctrl and glfu_datapath; depends on nothing else.
`ifndef GCD_LCM_FRACTION_UNIT_DEFINES_SVH
`define GCD_LCM_FRACTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GLFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define GLFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/glfu_pkg.sv
// Shared types and codes for the gcd/lcm/fraction unit.
// No dependencies; used by every module of the unit.
`default_nettype none

package glfu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

  localparam logic [1:0] OP_GCD    = 2'd0;
  localparam logic [1:0] OP_LCM    = 2'd1;
  localparam logic [1:0] OP_REDUCE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [DATA_WIDTH-1:0] first_operand;
    logic signed [DATA_WIDTH-1:0] second_operand;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] first_result;
    logic signed [DATA_WIDTH-1:0] second_result;
    logic [1:0]                   status;
  } out_item_t;

  typedef enum logic [1:0] {
    SRC_EUCLID,
    SRC_NUM,
    SRC_DEN
  } div_src_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_EUC_TEST,
    CS_EUC_DIV,
    CS_EUC_ADV,
    CS_Q0_DIV,
    CS_Q0_SAVE,
    CS_Q1_DIV,
    CS_Q1_SAVE,
    CS_MUL,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_src_t div_src;
    logic     div_step;
    logic     euc_advance;
    logic     save_q0;
    logic     save_q1;
    logic     mul_start;
    logic     mul_step;
    logic     out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       x_zero;
    logic       y_zero;
    logic       b_zero;
    logic       cnt_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/glfu_datapath.sv
// Datapath of the gcd/lcm/fraction unit: operand registers, shared
// divide/multiply shift unit, result formatting and output register.
// Depends on glfu_pkg and the unit's assertion macros.
`default_nettype none
`include "gcd_lcm_fraction_unit_defines.svh"

module glfu_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  glfu_pkg::in_item_t  in_data,
  input  glfu_pkg::dp_cmd_t   cmd,
  output glfu_pkg::dp_stat_t  stat,
  output glfu_pkg::out_item_t out_data
);

  localparam int W  = glfu_pkg::DATA_WIDTH;
  localparam int CW = glfu_pkg::CNT_WIDTH;
  localparam logic [W-1:0]   HALF      = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] HALF_WIDE = {{W{1'b0}}, HALF};

  logic [1:0]    op_r;
  logic          x_neg_r, y_neg_r, a_neg_r, b_neg_r;
  logic [W-1:0]  x_mag_r, y_mag_r, a_mag_r, b_mag_r;
  logic [W-1:0]  div_rem_r, div_quo_r, div_dsr_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  q0_r, q1_r;
  glfu_pkg::out_item_t out_data_r;

  logic [W-1:0]  in_x_raw, in_y_raw, in_x_mag, in_y_mag;
  logic [W-1:0]  dvd_sel, dsr_sel;
  logic [W:0]    part;
  logic [W+1:0]  diff;
  logic          q_bit;
  logic [W-1:0]  rem_step;
  logic [W:0]    mul_sum;
  logic [2*W-1:0] prod;
  logic          lcm_neg;
  logic          r0_neg, r1_neg;
  logic [W-1:0]  r0_mag, r1_mag;
  logic [1:0]    st;
  glfu_pkg::out_item_t res;

  assign in_x_raw = in_data.first_operand;
  assign in_y_raw = in_data.second_operand;
  assign in_x_mag = in_x_raw[W-1] ? (~in_x_raw + 1'b1) : in_x_raw;
  assign in_y_mag = in_y_raw[W-1] ? (~in_y_raw + 1'b1) : in_y_raw;

  always_comb begin
    unique case (cmd.div_src)
      glfu_pkg::SRC_EUCLID: begin
        dvd_sel = a_mag_r;
        dsr_sel = b_mag_r;
      end
      glfu_pkg::SRC_NUM: begin
        dvd_sel = x_mag_r;
        dsr_sel = a_mag_r;
      end
      glfu_pkg::SRC_DEN: begin
        dvd_sel = y_mag_r;
        dsr_sel = a_mag_r;
      end
      default: begin
        dvd_sel = a_mag_r;
        dsr_sel = b_mag_r;
      end
    endcase
  end

  assign part     = {div_rem_r, div_quo_r[W-1]};
  assign diff     = {1'b0, part} - {2'b00, div_dsr_r};
  assign q_bit    = !diff[W+1];
  assign rem_step = q_bit ? diff[W-1:0] : part[W-1:0];
  assign mul_sum  = {1'b0, div_rem_r} + (div_quo_r[0] ? {1'b0, div_dsr_r} : {(W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      x_neg_r <= in_x_raw[W-1];
      x_mag_r <= in_x_mag;
      y_neg_r <= in_y_raw[W-1];
      y_mag_r <= in_y_mag;
      a_neg_r <= in_x_raw[W-1];
      a_mag_r <= in_x_mag;
      b_neg_r <= in_y_raw[W-1];
      b_mag_r <= in_y_mag;
    end else if (cmd.euc_advance) begin
      a_neg_r <= b_neg_r;
      a_mag_r <= b_mag_r;
      b_neg_r <= a_neg_r && (div_rem_r != '0);
      b_mag_r <= div_rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_quo_r <= dvd_sel;
      div_dsr_r <= dsr_sel;
      cnt_r     <= '0;
    end else if (cmd.mul_start) begin
      div_rem_r <= '0;
      div_dsr_r <= y_mag_r;
      cnt_r     <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= rem_step;
      div_quo_r <= {div_quo_r[W-2:0], q_bit};
      cnt_r     <= cnt_r + 1'b1;
    end else if (cmd.mul_step) begin
      div_rem_r <= mul_sum[W:1];
      div_quo_r <= {mul_sum[0], div_quo_r[W-1:1]};
      cnt_r     <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_q0) begin
      q0_r <= div_quo_r;
    end
    if (cmd.save_q1) begin
      q1_r <= div_quo_r;
    end
    if (cmd.out_write) begin
      out_data_r <= res;
    end
  end

  assign prod    = {div_rem_r, div_quo_r};
  assign lcm_neg = x_neg_r ^ y_neg_r ^ a_neg_r;

  always_comb begin
    r0_neg = 1'b0;
    r0_mag = '0;
    r1_neg = 1'b0;
    r1_mag = '0;
    st     = glfu_pkg::STAT_OK;
    unique case (op_r)
      glfu_pkg::OP_GCD: begin
        r0_neg = a_neg_r;
        r0_mag = a_mag_r;
      end
      glfu_pkg::OP_LCM: begin
        if (stat.x_zero && stat.y_zero) begin
          st = glfu_pkg::STAT_DIV_ZERO;
        end else if (prod > HALF_WIDE || (prod == HALF_WIDE && !lcm_neg)) begin
          st = glfu_pkg::STAT_OVERFLOW;
        end else begin
          r0_neg = lcm_neg;
          r0_mag = prod[W-1:0];
        end
      end
      glfu_pkg::OP_REDUCE: begin
        if (stat.y_zero) begin
          st = glfu_pkg::STAT_DIV_ZERO;
        end else begin
          r0_neg = x_neg_r ^ a_neg_r;
          r0_mag = q0_r;
          r1_neg = y_neg_r ^ a_neg_r;
          r1_mag = q1_r;
          if ((r0_neg ? (r0_mag > HALF) : (r0_mag >= HALF)) ||
              (r1_neg ? (r1_mag > HALF) : (r1_mag >= HALF))) begin
            st = glfu_pkg::STAT_OVERFLOW;
          end
        end
      end
      glfu_pkg::OP_NONE: begin
        st = glfu_pkg::STAT_OK;
      end
    endcase
    if (st != glfu_pkg::STAT_OK) begin
      r0_mag = '0;
      r1_mag = '0;
    end
    res.first_result  = r0_neg ? (~r0_mag + 1'b1) : r0_mag;
    res.second_result = r1_neg ? (~r1_mag + 1'b1) : r1_mag;
    res.status        = st;
  end

  assign stat.op       = op_r;
  assign stat.x_zero   = (x_mag_r == '0);
  assign stat.y_zero   = (y_mag_r == '0);
  assign stat.b_zero   = (b_mag_r == '0);
  assign stat.cnt_last = (cnt_r == CW'(W - 1));
  assign out_data      = out_data_r;

  `GLFU_ASSERT_NOW(a_rem_below_divisor, clk, rst_n, cmd.euc_advance, div_rem_r < b_mag_r, "remainder not below divisor")
  `GLFU_ASSERT_NOW(a_gcd_nonzero, clk, rst_n, cmd.save_q0, a_mag_r != '0, "quotient taken with zero gcd")

endmodule

`default_nettype wire

FILE: rtl/glfu_ctrl.sv
// Controller of the gcd/lcm/fraction unit: sequences Euclid steps,
// final divisions and the lcm multiply, and owns both handshakes.
// Depends on glfu_pkg and the unit's assertion macros.
`default_nettype none
`include "gcd_lcm_fraction_unit_defines.svh"

module glfu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  glfu_pkg::dp_stat_t stat,
  output glfu_pkg::dp_cmd_t  cmd
);

  glfu_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != glfu_pkg::CS_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      glfu_pkg::CS_IDLE: begin
        if (in_valid) state_nxt = glfu_pkg::CS_DISPATCH;
      end
      glfu_pkg::CS_DISPATCH: begin
        if (stat.op == glfu_pkg::OP_NONE ||
            (stat.op == glfu_pkg::OP_LCM && stat.x_zero && stat.y_zero) ||
            (stat.op == glfu_pkg::OP_REDUCE && stat.y_zero)) begin
          state_nxt = glfu_pkg::CS_FINISH;
        end else begin
          state_nxt = glfu_pkg::CS_EUC_TEST;
        end
      end
      glfu_pkg::CS_EUC_TEST: begin
        if (!stat.b_zero) state_nxt = glfu_pkg::CS_EUC_DIV;
        else if (stat.op == glfu_pkg::OP_GCD) state_nxt = glfu_pkg::CS_FINISH;
        else state_nxt = glfu_pkg::CS_Q0_DIV;
      end
      glfu_pkg::CS_EUC_DIV: begin
        if (stat.cnt_last) state_nxt = glfu_pkg::CS_EUC_ADV;
      end
      glfu_pkg::CS_EUC_ADV: begin
        state_nxt = glfu_pkg::CS_EUC_TEST;
      end
      glfu_pkg::CS_Q0_DIV: begin
        if (stat.cnt_last) state_nxt = glfu_pkg::CS_Q0_SAVE;
      end
      glfu_pkg::CS_Q0_SAVE: begin
        if (stat.op == glfu_pkg::OP_LCM) state_nxt = glfu_pkg::CS_MUL;
        else state_nxt = glfu_pkg::CS_Q1_DIV;
      end
      glfu_pkg::CS_Q1_DIV: begin
        if (stat.cnt_last) state_nxt = glfu_pkg::CS_Q1_SAVE;
      end
      glfu_pkg::CS_Q1_SAVE: begin
        state_nxt = glfu_pkg::CS_FINISH;
      end
      glfu_pkg::CS_MUL: begin
        if (stat.cnt_last) state_nxt = glfu_pkg::CS_FINISH;
      end
      glfu_pkg::CS_FINISH: begin
        if (slot_free) state_nxt = glfu_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = glfu_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      glfu_pkg::CS_IDLE: begin
        cmd.load = in_valid;
      end
      glfu_pkg::CS_EUC_TEST: begin
        if (!stat.b_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = glfu_pkg::SRC_EUCLID;
        end else if (stat.op != glfu_pkg::OP_GCD) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = glfu_pkg::SRC_NUM;
        end
      end
      glfu_pkg::CS_EUC_DIV, glfu_pkg::CS_Q0_DIV, glfu_pkg::CS_Q1_DIV: begin
        cmd.div_step = 1'b1;
      end
      glfu_pkg::CS_EUC_ADV: begin
        cmd.euc_advance = 1'b1;
      end
      glfu_pkg::CS_Q0_SAVE: begin
        cmd.save_q0 = 1'b1;
        if (stat.op == glfu_pkg::OP_LCM) begin
          cmd.mul_start = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = glfu_pkg::SRC_DEN;
        end
      end
      glfu_pkg::CS_Q1_SAVE: begin
        cmd.save_q1 = 1'b1;
      end
      glfu_pkg::CS_MUL: begin
        cmd.mul_step = 1'b1;
      end
      glfu_pkg::CS_FINISH: begin
        cmd.out_write = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_write || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glfu_pkg::CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GLFU_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && !in_stall, state_r == glfu_pkg::CS_DISPATCH, "accepted item did not start")
  `GLFU_ASSERT_NOW(a_valid_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == glfu_pkg::CS_FINISH, "result item raised outside finish")

endmodule

`default_nettype wire

FILE: rtl/gcd_lcm_fraction_unit.sv
// Integer gcd / lcm / fraction-reduction unit on signed 32-bit operands. One item at a time:
// an accepted item runs Euclid's algorithm (C truncated remainder, so the gcd keeps the sign
// that rule gives) on one shared restoring divider that retires one quotient bit per cycle.
// Loading and dispatch come first, then each Euclid step (divider start, quotient bits, advance),
// then the closing zero test. After that, gcd goes straight to finish, lcm adds a quotient and a
// shift-add multiply, and fraction reduction adds two quotients. The result sits in an output
// register, so the next item is taken while it waits; the finish cycle holds until that register
// is free.
// Depends on glfu_pkg, glfu_ctrl and glfu_datapath.
`default_nettype none

module gcd_lcm_fraction_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  glfu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output glfu_pkg::out_item_t out_data
);

  glfu_pkg::dp_cmd_t  cmd;
  glfu_pkg::dp_stat_t stat;

  glfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  glfu_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
